[rtl/core/bda_pkg.sv]
// shared constants and types for the button debounce with auto-repeat block
// no dependencies

package bda_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int DELAY_W     = 16;

    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RESET = DELAY_W'(500);

    // per-button controls handed from the top level to each button cell
    typedef struct packed {
        logic advance;
        logic pin;
        logic clr;
    } t_btn_ctrl;

endpackage

[rtl/core/bda_stream_if.sv]
// valid/ready stream interfaces for the tick input and the flag result
// width follows the button count, no package dependency

interface bda_in_if #(
    parameter int NUM_BUTTONS = 4
);
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] pin_levels;
    logic [NUM_BUTTONS-1:0] clear_mask;

    modport source (output valid, output pin_levels, output clear_mask, input ready);
    modport sink   (input valid, input pin_levels, input clear_mask, output ready);
endinterface

interface bda_out_if #(
    parameter int NUM_BUTTONS = 4
);
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] press_flags;

    modport source (output valid, output press_flags, input ready);
    modport sink   (input valid, input press_flags, output ready);
endinterface

[rtl/core/button_debounce_autorepeat.sv]
// top level of the button debounce with auto-repeat block
// uses bda_pkg, bda_in_if, bda_out_if and bda_button
//
// Each accepted request is one tick: a raw active-low level and a flag-clear bit per
// button. A button qualifies as pressed once three consecutive ticks agree; a press
// raises its sticky flag, and a held button raises it again every repeat_delay + 1
// ticks (every second tick when repeat_delay is zero or one).
// The block takes one tick per clock unless it stalls. A tick passes an input register
// and then a result register: its flags are loaded into the result register once that
// register is free or its result is taken. The output register decouples the two
// sides, and the input stalls only while a result is waiting and the input register is
// full. repeat_delay (reset 500) is written through i_cfg_we / i_cfg_data; the user
// must write it only while the block is idle, as the block does not enforce this.

module button_debounce_autorepeat #(
    parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bda_pkg::DELAY_W-1:0] i_cfg_data,
    bda_in_if.sink                      i_in,
    bda_out_if.source                   o_out
);

    logic [bda_pkg::DELAY_W-1:0] r_repeat_delay;
    logic                        r_in_valid, r_out_valid;
    logic [NUM_BUTTONS-1:0]      r_pins, r_clr, r_flags;
    logic [NUM_BUTTONS-1:0]      n_flags;
    logic                        advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay <= bda_pkg::REPEAT_DELAY_RESET;
        end else if (i_cfg_we) begin
            r_repeat_delay <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_pins <= i_in.pin_levels;
            r_clr  <= i_in.clear_mask;
        end
        if (advance) begin
            r_flags <= n_flags;
        end
    end

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        bda_pkg::t_btn_ctrl ctrl;

        assign ctrl.advance = advance;
        assign ctrl.pin     = r_pins[b];
        assign ctrl.clr     = r_clr[b];

        bda_button u_button (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (ctrl),
            .i_repeat_delay (r_repeat_delay),
            .o_flag_next    (n_flags[b])
        );
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.press_flags = r_flags;

endmodule

[rtl/core/bda_button.sv]
// one button: three-sample shift, qualified level, hold countdown, sticky flag
// uses bda_pkg for the control struct and countdown width

module bda_button (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bda_pkg::t_btn_ctrl            i_ctrl,
    input  logic [bda_pkg::DELAY_W-1:0]   i_repeat_delay,
    output logic                          o_flag_next
);

    logic                        r_newest, r_middle, r_qual, r_flag;
    logic [bda_pkg::DELAY_W-1:0] r_cnt;
    logic                        n_qual, n_flag;
    logic [bda_pkg::DELAY_W-1:0] n_cnt, cnt_dec;
    logic                        agree;

    // samples after the shift: pin is newest, r_newest middle, r_middle oldest
    assign agree   = (i_ctrl.pin == r_newest) && (r_newest == r_middle);
    assign cnt_dec = (r_cnt != '0) ? r_cnt - 1'b1 : r_cnt;

    always_comb begin
        n_qual = r_qual;
        n_cnt  = r_cnt;
        n_flag = r_flag & ~i_ctrl.clr;
        if (agree) begin
            if (r_middle != r_qual) begin
                n_qual = r_middle;
                if (!r_middle) begin
                    n_cnt  = i_repeat_delay;
                    n_flag = 1'b1;
                end
            end else begin
                n_cnt = cnt_dec;
                // countdown expired: release so a held button re-qualifies
                if (cnt_dec == '0) begin
                    n_qual = 1'b1;
                end
            end
        end
    end

    assign o_flag_next = n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= 1'b1;
            r_middle <= 1'b1;
            r_qual   <= 1'b1;
            r_cnt    <= '0;
            r_flag   <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_newest <= i_ctrl.pin;
            r_middle <= r_newest;
            r_qual   <= n_qual;
            r_cnt    <= n_cnt;
            r_flag   <= n_flag;
        end
    end

endmodule

[rtl/core/bda_checker.sv]
// port-level assertions for button_debounce_autorepeat, bound to the top level
// sees only the top level ports, no package dependency

module bda_checker #(
    parameter int NUM_BUTTONS = 4
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [NUM_BUTTONS-1:0] i_press_flags
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its flags
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_press_flags))
        else $error("result changed while stalled");

    // with no result waiting the block always takes a request
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused with empty output");

    // a new result has passed the input register and the result register after its request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without matching request");

endmodule

bind button_debounce_autorepeat bda_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_press_flags (o_out.press_flags)
);
